FILE: hdl/kbmp_pkg.sv
// Shared types, constants and the frame checksum function of the keypad bus poller.
// Depends on nothing; every other file of the block imports it.
package kbmp_pkg;

	localparam int TIME_BITS = 32;
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);

	// Input item opcodes.
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_RX_BYTE = 2'd1;
	localparam logic [1:0] OP_END_BURST = 2'd2;

	// Result kinds.
	localparam logic [1:0] RK_TX = 2'd0;
	localparam logic [1:0] RK_KEY = 2'd1;
	localparam logic [1:0] RK_SCREEN = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_DEVICE_ADDRESS = 3'd0;
	localparam logic [2:0] REG_SECOND_POLL_DELAY = 3'd1;
	localparam logic [2:0] REG_STATUS_POLL_PERIOD = 3'd2;
	localparam logic [2:0] REG_SCREEN_PERIOD = 3'd3;
	localparam logic [2:0] REG_ACTIVITY_PERIOD = 3'd4;

	// Frame bytes.
	localparam logic [7:0] CHK_SEED = 8'hAA;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] CMD_START = 8'h0E;
	localparam logic [7:0] CMD_STATUS = 8'h0F;
	localparam logic [7:0] CMD_ACTIVITY = 8'h19;
	localparam logic [7:0] ACTIVITY_ARG = 8'h01;
	localparam logic [7:0] CMD_ACK = 8'h0B;
	localparam logic [7:0] ACK_ODD = 8'h02;
	localparam logic [7:0] KEY_SOURCE = 8'h11;
	localparam logic [7:0] KEY_FRAME = 8'hF4;
	localparam logic [7:0] KEY_CODE_MAX = 8'h0F;

	typedef enum logic [1:0] {
		CMD_FRAME,
		CMD_SCREEN,
		CMD_KEY
	} cmd_kind_t;

	// One unit of work handed from the front to the back.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [3:0]  code;
		logic [7:0]  chk;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  device_address;
		logic [15:0] second_poll_delay;
		logic [15:0] status_poll_period;
		logic [15:0] screen_period;
		logic [15:0] activity_period;
	} cfg_t;

	// Checksum: 0xAA plus the three payload bytes, carries out of bit 7 added back in.
	function automatic logic [7:0] fold_sum(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [9:0] t;
		t = 10'(CHK_SEED) + 10'(a) + 10'(b) + 10'(c);
		return t[7:0] + 8'(t[9:8]);
	endfunction

endpackage

FILE: hdl/kbmp_cmd_fifo.sv
// Short command queue between the front and the back of the keypad bus poller.
// Depends on kbmp_pkg for the command type and depth.
module kbmp_cmd_fifo import kbmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic q_full,
	input  logic rd,
	output cmd_t rdata,
	output logic q_empty
);

	cmd_t mem_q [CMD_DEPTH];
	logic [CMD_PTR_BITS-1:0] wptr_q;
	logic [CMD_PTR_BITS-1:0] rptr_q;
	logic [CMD_PTR_BITS:0] count_q;

	assign q_full = (count_q == (CMD_PTR_BITS+1)'(CMD_DEPTH));
	assign q_empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (CMD_PTR_BITS+1)'(CMD_DEPTH))
		else $error("command queue count beyond its depth");

endmodule

FILE: hdl/kbmp_front.sv
// Front of the keypad bus poller: accepts items, runs the poll timers and the
// receive buffer; issues commands one per cycle unless q_full. Uses kbmp_pkg.
module kbmp_front import kbmp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] opcode,
	input  logic [7:0] rx_byte,
	output logic       full,
	input  cfg_t       cfg,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	localparam int P_START = 0;
	localparam int P_STATUS = 1;
	localparam int P_SCREEN = 2;
	localparam int P_ACTIVITY = 3;
	localparam int P_KEY = 4;
	localparam int P_BITS = 5;

	localparam logic [1:0] LC_NONE = 2'd0;
	localparam logic [1:0] LC_STATUS = 2'd1;
	localparam logic [1:0] LC_SCREEN = 2'd2;
	localparam logic [1:0] LC_ACTIVITY = 2'd3;

	logic [TIME_BITS-1:0] time_q, last_status_q, last_screen_q, last_activity_q;
	logic start_sent_q, second_sent_q, ack_flag_q;
	logic [1:0] last_command_q;
	logic [7:0] rx_buf_q [4];
	logic [2:0] rx_count_q;
	logic [P_BITS-1:0] pend_q;
	logic [3:0] key_code_q;
	logic [7:0] key_chk_q;
	logic [7:0] ack_arg_q;

	logic [TIME_BITS-1:0] tn;
	logic accept, is_tick, is_byte, is_eob;
	logic el_delay, el_status, el_screen, el_activity;
	logic start_f, sec_f, stat_f, scr_f, act_f, key_f;
	logic pend_one, issue;
	logic [P_BITS-1:0] sel, new_mask;

	assign tn = time_q + 1'b1;
	assign el_delay = (tn - last_status_q) > TIME_BITS'(cfg.second_poll_delay);
	assign el_status = (tn - last_status_q) > TIME_BITS'(cfg.status_poll_period);
	assign el_screen = (tn - last_screen_q) > TIME_BITS'(cfg.screen_period);
	assign el_activity = (tn - last_activity_q) > TIME_BITS'(cfg.activity_period);

	// Before the start frame the status timer restarts on this very tick, so
	// neither status branch can fire.
	assign start_f = !start_sent_q;
	assign sec_f = start_sent_q && !second_sent_q && el_delay;
	assign stat_f = start_sent_q && !(!second_sent_q && el_delay) && el_status;
	assign scr_f = (second_sent_q || sec_f) && el_screen;
	assign act_f = el_activity;

	assign key_f = (rx_count_q == 3'd4) && (rx_buf_q[0] == KEY_SOURCE)
		&& (rx_buf_q[1] == KEY_FRAME)
		&& (fold_sum(KEY_SOURCE, KEY_FRAME, rx_buf_q[2]) == rx_buf_q[3])
		&& (last_command_q == LC_ACTIVITY) && (rx_buf_q[2] <= KEY_CODE_MAX);

	assign is_tick = (opcode == OP_TICK);
	assign is_byte = (opcode == OP_RX_BYTE);
	assign is_eob = (opcode == OP_END_BURST);

	always_comb begin
		new_mask = '0;
		if (is_tick) begin
			new_mask[P_START] = start_f;
			new_mask[P_STATUS] = sec_f || stat_f;
			new_mask[P_SCREEN] = scr_f;
			new_mask[P_ACTIVITY] = act_f;
		end else if (is_eob) begin
			new_mask[P_KEY] = key_f;
		end
	end

	assign pend_one = ((pend_q & (pend_q - 1'b1)) == '0);
	assign issue = (pend_q != '0) && !q_full;
	assign full = (pend_q != '0) && !(pend_one && !q_full);
	assign accept = push && !full;
	assign sel = pend_q & (~pend_q + 1'b1);
	assign q_push = issue;

	always_comb begin
		q_cmd = '{kind: CMD_FRAME, b1: BYTE_ZERO, b2: BYTE_ZERO, code: 4'd0,
			chk: 8'd0, last: pend_one};
		if (sel[P_START]) begin
			q_cmd.b2 = CMD_START;
		end else if (sel[P_STATUS]) begin
			q_cmd.b2 = CMD_STATUS;
		end else if (sel[P_SCREEN]) begin
			q_cmd.kind = CMD_SCREEN;
		end else if (sel[P_ACTIVITY]) begin
			q_cmd.b1 = CMD_ACTIVITY;
			q_cmd.b2 = ACTIVITY_ARG;
		end else if (sel[P_KEY]) begin
			q_cmd.kind = CMD_KEY;
			q_cmd.b1 = CMD_ACK;
			q_cmd.b2 = ack_arg_q;
			q_cmd.code = key_code_q;
			q_cmd.chk = key_chk_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_byte && rx_count_q < 3'd4) begin
			rx_buf_q[rx_count_q[1:0]] <= rx_byte;
		end
		if (accept && is_eob && key_f) begin
			key_code_q <= rx_buf_q[2][3:0];
			key_chk_q <= rx_buf_q[3];
			ack_arg_q <= ack_flag_q ? ACK_ODD : BYTE_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			last_status_q <= '0;
			last_screen_q <= '0;
			last_activity_q <= '0;
			start_sent_q <= 1'b0;
			second_sent_q <= 1'b0;
			last_command_q <= LC_NONE;
			ack_flag_q <= 1'b0;
			rx_count_q <= '0;
			pend_q <= '0;
		end else begin
			// An item is only taken once the last pending command goes out.
			if (accept) begin
				pend_q <= new_mask;
			end else if (issue) begin
				pend_q <= pend_q & ~sel;
			end
			if (accept) begin
				if (is_tick) begin
					time_q <= tn;
					if (start_f || sec_f || stat_f) begin
						last_status_q <= tn;
					end
					start_sent_q <= 1'b1;
					if (sec_f) begin
						second_sent_q <= 1'b1;
					end
					if (scr_f) begin
						last_screen_q <= tn;
					end
					if (act_f) begin
						last_activity_q <= tn;
					end
					if (act_f) begin
						last_command_q <= LC_ACTIVITY;
					end else if (scr_f) begin
						last_command_q <= LC_SCREEN;
					end else if (sec_f || stat_f) begin
						last_command_q <= LC_STATUS;
					end
				end else if (is_byte) begin
					if (rx_count_q < 3'd5) begin
						rx_count_q <= rx_count_q + 1'b1;
					end
				end else if (is_eob) begin
					rx_count_q <= '0;
					if (key_f) begin
						ack_flag_q <= !ack_flag_q;
					end
				end
			end
		end
	end

	a_first_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_tick && !start_sent_q |=> pend_q[P_START])
		else $error("first tick did not schedule the start frame");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command issued into a full queue");

endmodule

FILE: hdl/kbmp_back.sv
// Back of the keypad bus poller: expands queued commands into result items and
// holds them in the output register. Depends on kbmp_pkg.
module kbmp_back import kbmp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] device_address,
	input  logic       q_empty,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] result_kind,
	output logic [7:0] tx_byte,
	output logic       frame_end,
	output logic [3:0] key_code,
	output logic [7:0] key_check,
	output logic       run_last
);

	cmd_t cmd_q;
	logic active_q;
	logic [2:0] step_q;
	logic out_valid_q;

	logic advance, step_last;
	logic [1:0] r_kind;
	logic [7:0] r_tx;
	logic r_end;
	logic [3:0] r_code;
	logic [7:0] r_chk;

	assign advance = active_q && (!out_valid_q || pop);
	assign q_pop = !q_empty && (!active_q || (advance && step_last));
	assign empty = !out_valid_q;

	always_comb begin
		case (cmd_q.kind)
			CMD_SCREEN: step_last = (step_q == 3'd0);
			CMD_KEY: step_last = (step_q == 3'd4);
			default: step_last = (step_q == 3'd3);
		endcase
	end

	always_comb begin
		r_kind = RK_TX;
		r_tx = 8'd0;
		r_end = 1'b0;
		r_code = 4'd0;
		r_chk = 8'd0;
		if (cmd_q.kind == CMD_SCREEN) begin
			r_kind = RK_SCREEN;
		end else begin
			case (step_q)
				3'd0: r_tx = device_address;
				3'd1: r_tx = cmd_q.b1;
				3'd2: r_tx = cmd_q.b2;
				3'd3: begin
					r_tx = fold_sum(device_address, cmd_q.b1, cmd_q.b2);
					r_end = 1'b1;
				end
				default: begin
					// The key report follows the acknowledge frame.
					r_kind = RK_KEY;
					r_code = cmd_q.code;
					r_chk = cmd_q.chk;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (advance) begin
			result_kind <= r_kind;
			tx_byte <= r_tx;
			frame_end <= r_end;
			key_code <= r_code;
			key_check <= r_chk;
			run_last <= cmd_q.last && step_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				active_q <= 1'b1;
				step_q <= '0;
			end else if (advance) begin
				if (step_last) begin
					active_q <= 1'b0;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	a_screen_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && cmd_q.kind == CMD_SCREEN |-> step_q == 3'd0)
		else $error("screen marker command ran past its only step");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command taken from an empty queue");

endmodule

FILE: hdl/keypad_bus_master_poller_core.sv
// Top level of the keypad bus poller: configuration registers, front, command
// queue and back. Depends on kbmp_pkg, kbmp_front, kbmp_cmd_fifo and kbmp_back.
//
// Input items (opcode, rx_byte) enter through push/full: a tick advances the
// millisecond clock and may schedule the start frame, a status poll, a screen
// marker and an activity poll; a received byte is buffered; an end of burst
// checks the buffered key frame and may schedule an acknowledge plus a report.
// Result items leave through empty/pop, oldest first; run_last marks the last
// result of an item. Its first result passes the pending mask, the command
// queue, the back's command register and the output register. The back
// delivers one result per cycle while pop keeps up, so a tick that fires the
// status poll, the screen marker and the activity poll gives nine results;
// the front issues one command per cycle into a 4-entry queue while it has
// room, and a new item is taken in the cycle that the last pending command of
// the previous one goes into the queue; items with no result are taken each
// cycle. When pop stays low the output register holds, the back and then the
// queue fill, and full rises; nothing is lost. Reset clears timers, flags, the
// receive count and all queues, and loads the register reset values.
// Configuration is written through wr_en, wr_index and wr_data while idle.
module keypad_bus_master_poller_core import kbmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [7:0]  tx_byte,
	output logic        frame_end,
	output logic [3:0]  key_code,
	output logic [7:0]  key_check,
	output logic        run_last,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);

	cfg_t cfg_q;
	logic q_push, q_pop, q_full, q_empty;
	cmd_t q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= 8'd32;
			cfg_q.second_poll_delay <= 16'd200;
			cfg_q.status_poll_period <= 16'd1000;
			cfg_q.screen_period <= 16'd1000;
			cfg_q.activity_period <= 16'd50;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEVICE_ADDRESS: cfg_q.device_address <= wr_data[7:0];
				REG_SECOND_POLL_DELAY: cfg_q.second_poll_delay <= wr_data;
				REG_STATUS_POLL_PERIOD: cfg_q.status_poll_period <= wr_data;
				REG_SCREEN_PERIOD: cfg_q.screen_period <= wr_data;
				REG_ACTIVITY_PERIOD: cfg_q.activity_period <= wr_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	kbmp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.opcode  (opcode),
		.rx_byte (rx_byte),
		.full    (full),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (q_wdata)
	);

	kbmp_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wdata   (q_wdata),
		.q_full  (q_full),
		.rd      (q_pop),
		.rdata   (q_rdata),
		.q_empty (q_empty)
	);

	kbmp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.device_address (cfg_q.device_address),
		.q_empty        (q_empty),
		.q_cmd          (q_rdata),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.result_kind    (result_kind),
		.tx_byte        (tx_byte),
		.frame_end      (frame_end),
		.key_code       (key_code),
		.key_check      (key_check),
		.run_last       (run_last)
	);

endmodule
